// ===== rtl/rsp_pkg.sv =====
// Shared types, codes and the sensor-to-sector map for the rotor sync phase tracker.
package rsp_pkg;

    typedef enum logic [1:0] {
        REQ_PERIOD = 2'd0,
        REQ_LOAD   = 2'd1,
        REQ_TARGET = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_ROTOR_OFFSET  = 2'd0,
        CFG_INTERPOLATION = 2'd1,
        CFG_HALL_CHECK    = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    // Rotor angle in steps of 60 degrees.
    typedef enum logic [2:0] {
        SEC_0   = 3'd0,
        SEC_60  = 3'd1,
        SEC_120 = 3'd2,
        SEC_180 = 3'd3,
        SEC_240 = 3'd4,
        SEC_300 = 3'd5
    } sector_t;

    localparam int OFFSET_BITS  = 24;
    localparam int SPEED_BITS   = 24;
    localparam int AMP_BITS     = 16;
    localparam int INDEX_BITS   = 4;
    localparam int PHASE_TOP_W  = 16;
    localparam int TOP_BYTE_W   = 8;
    localparam logic [INDEX_BITS-1:0] SENSOR_IDX_MIN = 4'd1;
    localparam logic [INDEX_BITS-1:0] SENSOR_IDX_MAX = 4'd11;
    localparam int STALL_LIMIT  = 128;

    localparam logic [OFFSET_BITS-1:0] ROTOR_OFFSET_RST = 24'h800000;

    function automatic sector_t sensor_sector(input logic [INDEX_BITS-1:0] idx);
        sector_t sec;
        case (idx)
            4'd1:    sec = SEC_240;
            4'd2:    sec = SEC_300;
            4'd3:    sec = SEC_0;
            4'd4:    sec = SEC_60;
            4'd5:    sec = SEC_120;
            4'd6:    sec = SEC_180;
            4'd7:    sec = SEC_240;
            4'd8:    sec = SEC_300;
            4'd9:    sec = SEC_0;
            4'd10:   sec = SEC_60;
            4'd11:   sec = SEC_120;
            default: sec = SEC_0;
        endcase
        return sec;
    endfunction

endpackage

// ===== rtl/rotor_sync_phase_tracker.sv =====
// Rotor sync phase tracker: stator phase accumulator with rotor sensor synchronization.
//
// Input channel (in_valid / in_stall) carries one request per transaction: a PWM
// period, a load of drive values, or a new target amplitude. Each accepted
// transaction yields exactly one result on the output channel (out_valid /
// out_stall) with the phase top, speed, amplitude and fault flags.
// A request passes the input register, then the update logic into the result
// register. Throughput is one transaction per cycle while out_stall is low,
// set by the state update loop (phase add, rotor error, speed
// correction and stall compare).
// When the receiver stalls, the result register holds; one more transaction is
// taken into the input register, then in_stall rises until the result drains.
// The configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while the block is idle (not enforced).
// Reset leaves the drive stopped, all state zero, rotor offset at half a turn,
// interpolation off and the hall check on.
module rotor_sync_phase_tracker
    import rsp_pkg::*;
#(
    parameter int ANGLE_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [OFFSET_BITS-1:0] cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic [INDEX_BITS-1:0]  sensor_pos,
    input  logic [SPEED_BITS-1:0]  load_speed,
    input  logic [AMP_BITS-1:0]    load_amplitude,
    input  logic                   load_sync,
    input  logic                   clear_phase,
    input  logic [AMP_BITS-1:0]    new_target,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [PHASE_TOP_W-1:0] phase_top,
    output logic [SPEED_BITS-1:0]  speed_now,
    output logic [AMP_BITS-1:0]    amplitude_now,
    output logic                   synced,
    output logic                   stall_event,
    output logic                   hall_event,
    output logic                   drive_off
);

    localparam int AW = ANGLE_BITS;

    localparam logic [63:0] ANG64_60  = ((64'd60  << AW) + 64'd180) / 64'd360;
    localparam logic [63:0] ANG64_120 = ((64'd120 << AW) + 64'd180) / 64'd360;
    localparam logic [63:0] ANG64_180 = ((64'd180 << AW) + 64'd180) / 64'd360;
    localparam logic [63:0] ANG64_240 = ((64'd240 << AW) + 64'd180) / 64'd360;
    localparam logic [63:0] ANG64_300 = ((64'd300 << AW) + 64'd180) / 64'd360;

    localparam logic [AW-1:0] ANG_60  = ANG64_60[AW-1:0];
    localparam logic [AW-1:0] ANG_120 = ANG64_120[AW-1:0];
    localparam logic [AW-1:0] ANG_180 = ANG64_180[AW-1:0];
    localparam logic [AW-1:0] ANG_240 = ANG64_240[AW-1:0];
    localparam logic [AW-1:0] ANG_300 = ANG64_300[AW-1:0];
    localparam logic [AW-1:0] STALL_LIM = AW'(STALL_LIMIT);

    // Configuration registers
    logic [OFFSET_BITS-1:0] rotor_offset_reg;
    logic                   interp_on_reg;
    logic                   hall_check_reg;

    // Input register
    logic                   in_valid_reg;
    req_type_t              in_req_reg;
    logic [INDEX_BITS-1:0]  in_index_reg;
    logic [SPEED_BITS-1:0]  in_speed_reg;
    logic [AMP_BITS-1:0]    in_amp_reg;
    logic                   in_sync_reg;
    logic                   in_clear_reg;
    logic [AMP_BITS-1:0]    in_target_reg;

    // Tracker state
    logic [AW-1:0]          stator_phase_reg, stator_phase_next;
    logic [AW-1:0]          speed_reg, speed_next;
    logic [AMP_BITS-1:0]    amplitude_reg, amplitude_next;
    logic [AMP_BITS-1:0]    target_reg, target_next;
    logic                   sync_on_reg, sync_on_next;
    logic                   drive_stopped_reg, drive_stopped_next;
    logic [AW-1:0]          known_pos_reg, known_pos_next;
    logic [AW-1:0]          est_angle_reg, est_angle_next;
    logic [INDEX_BITS-1:0]  prev_index_reg, prev_index_next;

    // Result register
    logic                   out_valid_reg;
    logic [PHASE_TOP_W-1:0] phase_top_reg;
    logic [SPEED_BITS-1:0]  speed_now_reg;
    logic [AMP_BITS-1:0]    amplitude_now_reg;
    logic                   synced_reg;
    logic                   stall_event_reg, stall_event_next;
    logic                   hall_event_reg, hall_event_next;
    logic                   drive_off_reg;

    logic                   out_free;
    logic                   process;
    logic                   in_accept;

    logic                   index_ok;
    logic                   index_new;
    sector_t                sector;
    logic [AW-1:0]          table_angle;
    logic [AW-1:0]          phase_sum;
    logic [TOP_BYTE_W-1:0]  est_top;
    logic [TOP_BYTE_W-1:0]  known_top;
    logic [TOP_BYTE_W-1:0]  top_dist;
    logic [AW-1:0]          rotor_angle;
    logic [AW-1:0]          rotor_error;
    logic [TOP_BYTE_W-1:0]  error_top;
    logic [AW-1:0]          speed_trim;

    assign cfg_ready = 1'b1;

    assign out_free  = !out_valid_reg || !out_stall;
    assign process   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_offset_reg <= ROTOR_OFFSET_RST;
            interp_on_reg    <= 1'b0;
            hall_check_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROTOR_OFFSET:  rotor_offset_reg <= cfg_data;
                CFG_INTERPOLATION: interp_on_reg    <= cfg_data[0];
                CFG_HALL_CHECK:    hall_check_reg   <= cfg_data[0];
                CFG_UNUSED:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_req_reg    <= REQ_NONE;
            in_index_reg  <= '0;
            in_speed_reg  <= '0;
            in_amp_reg    <= '0;
            in_sync_reg   <= 1'b0;
            in_clear_reg  <= 1'b0;
            in_target_reg <= '0;
        end
        else if (in_accept)
        begin
            in_req_reg    <= req_type_t'(req_type);
            in_index_reg  <= sensor_pos;
            in_speed_reg  <= load_speed;
            in_amp_reg    <= load_amplitude;
            in_sync_reg   <= load_sync;
            in_clear_reg  <= clear_phase;
            in_target_reg <= new_target;
        end
    end

    // Sensor decode and rotor angle
    assign index_ok  = (in_index_reg >= SENSOR_IDX_MIN) && (in_index_reg <= SENSOR_IDX_MAX);
    assign index_new = index_ok && (in_index_reg != prev_index_reg);
    assign sector    = sensor_sector(in_index_reg);
    assign phase_sum = stator_phase_reg + speed_reg;
    assign est_top   = est_angle_reg[AW-1 -: TOP_BYTE_W];
    assign known_top = known_pos_reg[AW-1 -: TOP_BYTE_W];
    assign top_dist  = (est_top > known_top) ? (est_top - known_top) : (known_top - est_top);

    always_comb
    begin
        unique case (sector)
            SEC_0:   table_angle = '0;
            SEC_60:  table_angle = ANG_60;
            SEC_120: table_angle = ANG_120;
            SEC_180: table_angle = ANG_180;
            SEC_240: table_angle = ANG_240;
            SEC_300: table_angle = ANG_300;
            default: table_angle = '0;
        endcase
    end

    always_comb
    begin
        known_pos_next  = known_pos_reg;
        est_angle_next  = est_angle_reg;
        prev_index_next = prev_index_reg;
        if (index_new)
        begin
            known_pos_next  = table_angle;
            prev_index_next = in_index_reg;
            if (interp_on_reg)
            begin
                est_angle_next = table_angle;
            end
        end
        else if (interp_on_reg && !top_dist[TOP_BYTE_W-1])
        begin
            // extrapolate while within half a turn of the last edge
            est_angle_next = est_angle_reg + speed_reg;
        end
        rotor_angle = interp_on_reg ? est_angle_next : known_pos_next;
    end

    // Speed correction from the signed top byte of the rotor-stator error
    assign rotor_error = rotor_angle + AW'(rotor_offset_reg) - phase_sum;
    assign error_top   = rotor_error[AW-1 -: TOP_BYTE_W];
    assign speed_trim  = speed_reg + {{(AW-TOP_BYTE_W){error_top[TOP_BYTE_W-1]}}, error_top};

    always_comb
    begin
        stator_phase_next  = stator_phase_reg;
        speed_next         = speed_reg;
        amplitude_next     = amplitude_reg;
        target_next        = target_reg;
        sync_on_next       = sync_on_reg;
        drive_stopped_next = drive_stopped_reg;
        stall_event_next   = 1'b0;
        hall_event_next    = 1'b0;
        unique case (in_req_reg)
            REQ_PERIOD:
            begin
                stator_phase_next = phase_sum;
                if (sync_on_reg)
                begin
                    priority if (hall_check_reg && !index_ok)
                    begin
                        hall_event_next = 1'b1;
                    end
                    else if (speed_trim < STALL_LIM)
                    begin
                        stall_event_next = 1'b1;
                    end
                    else
                    begin
                        speed_next = speed_trim;
                        if (amplitude_reg > target_reg)
                        begin
                            amplitude_next = amplitude_reg - AMP_BITS'(1);
                        end
                        else if (amplitude_reg < target_reg)
                        begin
                            amplitude_next = amplitude_reg + AMP_BITS'(1);
                        end
                    end
                    // drop the drive on either fault
                    if (hall_event_next || stall_event_next)
                    begin
                        sync_on_next       = 1'b0;
                        speed_next         = '0;
                        amplitude_next     = '0;
                        target_next        = '0;
                        drive_stopped_next = 1'b1;
                    end
                end
            end
            REQ_LOAD:
            begin
                speed_next         = AW'(in_speed_reg);
                amplitude_next     = in_amp_reg;
                sync_on_next       = in_sync_reg;
                target_next        = in_target_reg;
                drive_stopped_next = (AW'(in_speed_reg) == '0);
                if (in_clear_reg)
                begin
                    stator_phase_next = '0;
                end
            end
            REQ_TARGET:
            begin
                target_next = in_target_reg;
            end
            REQ_NONE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stator_phase_reg  <= '0;
            speed_reg         <= '0;
            amplitude_reg     <= '0;
            target_reg        <= '0;
            sync_on_reg       <= 1'b0;
            drive_stopped_reg <= 1'b1;
            known_pos_reg     <= '0;
            est_angle_reg     <= '0;
            prev_index_reg    <= '0;
        end
        else if (process)
        begin
            stator_phase_reg  <= stator_phase_next;
            speed_reg         <= speed_next;
            amplitude_reg     <= amplitude_next;
            target_reg        <= target_next;
            sync_on_reg       <= sync_on_next;
            drive_stopped_reg <= drive_stopped_next;
            // rotor tracking only advances on period transactions
            if (in_req_reg == REQ_PERIOD)
            begin
                known_pos_reg  <= known_pos_next;
                est_angle_reg  <= est_angle_next;
                prev_index_reg <= prev_index_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            phase_top_reg     <= stator_phase_next[AW-1 -: PHASE_TOP_W];
            speed_now_reg     <= SPEED_BITS'(speed_next);
            amplitude_now_reg <= amplitude_next;
            synced_reg        <= sync_on_next;
            stall_event_reg   <= stall_event_next;
            hall_event_reg    <= hall_event_next;
            drive_off_reg     <= drive_stopped_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase_top     = phase_top_reg;
    assign speed_now     = speed_now_reg;
    assign amplitude_now = amplitude_now_reg;
    assign synced        = synced_reg;
    assign stall_event   = stall_event_reg;
    assign hall_event    = hall_event_reg;
    assign drive_off     = drive_off_reg;

    a_one_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(stall_event && hall_event))
        else $error("stall and hall fault reported by one transaction");

    a_fault_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (stall_event || hall_event)) |->
            (drive_off && !synced && speed_now == '0 && amplitude_now == '0))
        else $error("fault result does not show the drive stopped");

    a_fault_state: assert property (@(posedge clk) disable iff (!rst_n)
        (process && (stall_event_next || hall_event_next)) |=>
            (drive_stopped_reg && !sync_on_reg && target_reg == '0))
        else $error("fault did not clear the drive state");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

endmodule

// ===== tb/phase_tracker_checker.sv =====
`timescale 1ns / 100ps
// Checker for the rotor sync phase tracker: predicts each result and compares it.
module phase_tracker_checker
    import rsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [OFFSET_BITS-1:0] cfg_data,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             req_type,
    input  logic [INDEX_BITS-1:0]  sensor_pos,
    input  logic [SPEED_BITS-1:0]  load_speed,
    input  logic [AMP_BITS-1:0]    load_amplitude,
    input  logic                   load_sync,
    input  logic                   clear_phase,
    input  logic [AMP_BITS-1:0]    new_target,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [PHASE_TOP_W-1:0] phase_top,
    input  logic [SPEED_BITS-1:0]  speed_now,
    input  logic [AMP_BITS-1:0]    amplitude_now,
    input  logic                   synced,
    input  logic                   stall_event,
    input  logic                   hall_event,
    input  logic                   drive_off,

    output int                     errors,
    output int                     pending,
    output int                     checked,
    output int                     stall_seen,
    output int                     hall_seen
);

    localparam int ANGLE_W = 24;

    typedef struct packed {
        logic [PHASE_TOP_W-1:0] phase_top;
        logic [SPEED_BITS-1:0]  speed;
        logic [AMP_BITS-1:0]    amplitude;
        logic                   synced;
        logic                   stall_ev;
        logic                   hall_ev;
        logic                   drive_off;
    } drive_report_t;

    // register copies
    logic [ANGLE_W-1:0]    offset_q;
    logic                  interp_q;
    logic                  hall_chk_q;

    // tracker state
    logic [ANGLE_W-1:0]    phase_acc;
    logic [ANGLE_W-1:0]    speed_acc;
    logic [AMP_BITS-1:0]   amp_acc;
    logic [AMP_BITS-1:0]   target_acc;
    logic                  sync_acc;
    logic                  stopped_acc;
    logic [ANGLE_W-1:0]    anchor_ang;
    logic [ANGLE_W-1:0]    est_ang;
    logic [INDEX_BITS-1:0] last_idx;

    drive_report_t report_q[$];
    drive_report_t want;
    int err_n;
    int checked_n;
    int stall_n;
    int hall_n;

    // Sensor index to 24-bit angle, rounded to nearest.
    function automatic logic [ANGLE_W-1:0] sensor_angle(input logic [INDEX_BITS-1:0] idx);
        logic [63:0] deg;
        logic [63:0] span;
        case (idx)
            4'd1, 4'd7:  deg = 64'd240;
            4'd2, 4'd8:  deg = 64'd300;
            4'd4, 4'd10: deg = 64'd60;
            4'd5, 4'd11: deg = 64'd120;
            4'd6:        deg = 64'd180;
            default:     deg = 64'd0;
        endcase
        span = ((deg << ANGLE_W) + 64'd180) / 64'd360;
        return span[ANGLE_W-1:0];
    endfunction

    function automatic void drop_drive();
        sync_acc    = 1'b0;
        speed_acc   = '0;
        amp_acc     = '0;
        target_acc  = '0;
        stopped_acc = 1'b1;
    endfunction

    function automatic drive_report_t advance_tracker(
        input req_type_t             rq,
        input logic [INDEX_BITS-1:0] idx,
        input logic [SPEED_BITS-1:0] ld_speed,
        input logic [AMP_BITS-1:0]   ld_amp,
        input logic                  ld_sync,
        input logic                  ld_clear,
        input logic [AMP_BITS-1:0]   ld_target
    );
        drive_report_t      rep;
        logic               idx_ok;
        logic [ANGLE_W-1:0] rotor;
        logic [ANGLE_W-1:0] err;
        logic [ANGLE_W-1:0] adj;
        logic [7:0]         eb;
        logic [7:0]         kb;
        logic [7:0]         gap;
        logic               st;
        logic               hl;
        st = 1'b0;
        hl = 1'b0;
        case (rq)
            REQ_PERIOD:
            begin
                idx_ok    = (idx >= SENSOR_IDX_MIN) && (idx <= SENSOR_IDX_MAX);
                phase_acc = phase_acc + speed_acc;
                if (idx_ok && idx != last_idx)
                begin
                    anchor_ang = sensor_angle(idx);
                    last_idx   = idx;
                    if (interp_q)
                        est_ang = anchor_ang;
                end
                else if (interp_q)
                begin
                    // advance the estimate only while it stays within half a turn
                    eb  = est_ang[ANGLE_W-1 -: 8];
                    kb  = anchor_ang[ANGLE_W-1 -: 8];
                    gap = (eb > kb) ? eb - kb : kb - eb;
                    if (gap < 8'd128)
                        est_ang = est_ang + speed_acc;
                end
                rotor = interp_q ? est_ang : anchor_ang;
                if (sync_acc)
                begin
                    if (hall_chk_q && !idx_ok)
                    begin
                        drop_drive();
                        hl = 1'b1;
                    end
                    else
                    begin
                        err = rotor + offset_q - phase_acc;
                        adj = speed_acc + {{(ANGLE_W-8){err[ANGLE_W-1]}}, err[ANGLE_W-1 -: 8]};
                        if (adj < ANGLE_W'(STALL_LIMIT))
                        begin
                            drop_drive();
                            st = 1'b1;
                        end
                        else
                        begin
                            speed_acc = adj;
                            if (amp_acc > target_acc)
                                amp_acc = amp_acc - 16'd1;
                            else if (amp_acc < target_acc)
                                amp_acc = amp_acc + 16'd1;
                        end
                    end
                end
            end
            REQ_LOAD:
            begin
                speed_acc  = ld_speed;
                amp_acc    = ld_amp;
                sync_acc   = ld_sync;
                target_acc = ld_target;
                if (ld_clear)
                    phase_acc = '0;
                stopped_acc = (ld_speed == '0);
            end
            REQ_TARGET:
            begin
                target_acc = ld_target;
            end
            default:
            begin
            end
        endcase
        rep.phase_top = phase_acc[ANGLE_W-1 -: PHASE_TOP_W];
        rep.speed     = speed_acc;
        rep.amplitude = amp_acc;
        rep.synced    = sync_acc;
        rep.stall_ev  = st;
        rep.hall_ev   = hl;
        rep.drive_off = stopped_acc;
        return rep;
    endfunction

    function automatic int field_bad(input string name, input logic [23:0] exp_v,
                                     input logic [23:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            offset_q    = ROTOR_OFFSET_RST;
            interp_q    = 1'b0;
            hall_chk_q  = 1'b1;
            phase_acc   = '0;
            speed_acc   = '0;
            amp_acc     = '0;
            target_acc  = '0;
            sync_acc    = 1'b0;
            stopped_acc = 1'b1;
            anchor_ang  = '0;
            est_ang     = '0;
            last_idx    = '0;
            report_q.delete();
            err_n       = 0;
            checked_n   = 0;
            stall_n     = 0;
            hall_n      = 0;
        end
        else
        begin
            // check results before queuing this edge's request
            if (out_valid && !out_stall)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result transaction with no request outstanding");
                    err_n++;
                end
                else
                begin
                    want  = report_q.pop_front();
                    err_n += field_bad("phase_top", 24'(want.phase_top), 24'(phase_top));
                    err_n += field_bad("speed_now", want.speed, speed_now);
                    err_n += field_bad("amplitude_now", 24'(want.amplitude), 24'(amplitude_now));
                    err_n += field_bad("synced", 24'(want.synced), 24'(synced));
                    err_n += field_bad("stall_event", 24'(want.stall_ev), 24'(stall_event));
                    err_n += field_bad("hall_event", 24'(want.hall_ev), 24'(hall_event));
                    err_n += field_bad("drive_off", 24'(want.drive_off), 24'(drive_off));
                    checked_n++;
                end
                if (stall_event)
                    stall_n++;
                if (hall_event)
                    hall_n++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ROTOR_OFFSET:  offset_q   = cfg_data;
                    CFG_INTERPOLATION: interp_q   = cfg_data[0];
                    CFG_HALL_CHECK:    hall_chk_q = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                report_q.push_back(advance_tracker(req_type_t'(req_type), sensor_pos,
                    load_speed, load_amplitude, load_sync, clear_phase, new_target));
        end
        errors     <= err_n;
        pending    <= report_q.size();
        checked    <= checked_n;
        stall_seen <= stall_n;
        hall_seen  <= hall_n;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top testbench for the rotor sync phase tracker: clock, reset, stimulus and verdict.
module tb
    import rsp_pkg::*;
();

    logic                   clk;
    logic                   rst_n          = 1'b0;

    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index      = '0;
    logic [OFFSET_BITS-1:0] cfg_data       = '0;

    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [1:0]             req_type       = '0;
    logic [INDEX_BITS-1:0]  sensor_pos     = '0;
    logic [SPEED_BITS-1:0]  load_speed     = '0;
    logic [AMP_BITS-1:0]    load_amplitude = '0;
    logic                   load_sync      = 1'b0;
    logic                   clear_phase    = 1'b0;
    logic [AMP_BITS-1:0]    new_target     = '0;

    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic [PHASE_TOP_W-1:0] phase_top;
    logic [SPEED_BITS-1:0]  speed_now;
    logic [AMP_BITS-1:0]    amplitude_now;
    logic                   synced;
    logic                   stall_event;
    logic                   hall_event;
    logic                   drive_off;

    int errors;
    int pending;
    int checked;
    int stall_seen;
    int hall_seen;
    int sent    = 0;
    bit idle_on = 1'b1;

    rotor_sync_phase_tracker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .sensor_pos     (sensor_pos),
        .load_speed     (load_speed),
        .load_amplitude (load_amplitude),
        .load_sync      (load_sync),
        .clear_phase    (clear_phase),
        .new_target     (new_target),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase_top      (phase_top),
        .speed_now      (speed_now),
        .amplitude_now  (amplitude_now),
        .synced         (synced),
        .stall_event    (stall_event),
        .hall_event     (hall_event),
        .drive_off      (drive_off)
    );

    phase_tracker_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .sensor_pos     (sensor_pos),
        .load_speed     (load_speed),
        .load_amplitude (load_amplitude),
        .load_sync      (load_sync),
        .clear_phase    (clear_phase),
        .new_target     (new_target),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase_top      (phase_top),
        .speed_now      (speed_now),
        .amplitude_now  (amplitude_now),
        .synced         (synced),
        .stall_event    (stall_event),
        .hall_event     (hall_event),
        .drive_off      (drive_off),
        .errors         (errors),
        .pending        (pending),
        .checked        (checked),
        .stall_seen     (stall_seen),
        .hall_seen      (hall_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver back-pressure in short bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send(input req_type_t rq, input logic [INDEX_BITS-1:0] idx,
                        input logic [SPEED_BITS-1:0] spd, input logic [AMP_BITS-1:0] amp,
                        input logic sync, input logic clr, input logic [AMP_BITS-1:0] tgt);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= rq;
        sensor_pos     <= idx;
        load_speed     <= spd;
        load_amplitude <= amp;
        load_sync      <= sync;
        clear_phase    <= clr;
        new_target     <= tgt;
        sent++;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_noise();
        send(req_type_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 24'($urandom),
             16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // Hold the sender until every outstanding result has drained.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [OFFSET_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SPEED_BITS-1:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return 24'($urandom_range(100, 400));
            3:       return 24'hFFFFFF - 24'($urandom_range(0, 300));
            default: return 24'($urandom_range(1000, 24'h3FFFFF));
        endcase
    endfunction

    // Load drive values, then run periods (sensor stepping or invalid) among other requests.
    task automatic run_commutation(input int len);
        logic [INDEX_BITS-1:0] pos;
        logic [AMP_BITS-1:0]   amp;
        logic [AMP_BITS-1:0]   tgt;
        int                    k;
        amp = 16'($urandom);
        tgt = ($urandom_range(0, 1) == 0) ? amp + 16'($urandom_range(0, 6)) - 16'd3
                                          : 16'($urandom);
        send(REQ_LOAD, 4'($urandom_range(0, 15)), pick_speed(), amp,
             1'($urandom_range(0, 9) != 0), 1'($urandom), tgt);
        pos = 4'($urandom_range(1, 11));
        for (k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 19))
                0:
                    send(REQ_PERIOD, ($urandom_range(0, 4) == 0) ? 4'd0
                         : 4'($urandom_range(12, 15)), 24'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom), 16'($urandom));
                1:
                    send(REQ_TARGET, 4'($urandom_range(0, 15)), 24'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom), 16'($urandom));
                2:
                    send(REQ_NONE, 4'($urandom_range(0, 15)), 24'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom), 16'($urandom));
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                        pos = (pos == SENSOR_IDX_MAX) ? SENSOR_IDX_MIN : pos + 4'd1;
                    send(REQ_PERIOD, pos, 24'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom), 16'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        int ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset register values
        send(REQ_PERIOD, 4'd0, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_NONE, 4'd15, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
        send(REQ_LOAD, 4'd0, 24'd0, 16'h0, 1'b1, 1'b1, 16'h0);
        send(REQ_PERIOD, 4'd3, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_LOAD, 4'd0, 24'd127, 16'd10, 1'b1, 1'b1, 16'd20);
        send(REQ_PERIOD, 4'd1, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_LOAD, 4'd0, 24'd128, 16'd100, 1'b1, 1'b1, 16'd102);
        send(REQ_PERIOD, 4'd9, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_PERIOD, 4'd9, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_PERIOD, 4'd11, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_LOAD, 4'd0, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0);
        send(REQ_PERIOD, 4'd2, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_LOAD, 4'd0, 24'h100000, 16'd5, 1'b1, 1'b1, 16'd3);
        send(REQ_PERIOD, 4'd4, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_PERIOD, 4'd5, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_TARGET, 4'd0, '0, '0, 1'b0, 1'b0, 16'hFFFF);
        send(REQ_PERIOD, 4'd6, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_PERIOD, 4'd0, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_LOAD, 4'd0, 24'h100000, 16'd40, 1'b1, 1'b0, 16'd40);
        send(REQ_PERIOD, 4'd12, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_LOAD, 4'd0, 24'h100000, 16'd40, 1'b1, 1'b0, 16'd40);
        send(REQ_PERIOD, 4'd15, '0, '0, 1'b0, 1'b0, '0);
        send(REQ_TARGET, 4'd0, '0, '0, 1'b0, 1'b0, 16'h0);
        send(REQ_LOAD, 4'd0, 24'h080000, 16'd7, 1'b0, 1'b0, 16'd9);
        send(REQ_PERIOD, 4'd7, '0, '0, 1'b0, 1'b0, '0);

        for (ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    write_reg(CFG_ROTOR_OFFSET, 24'h000000);
                    write_reg(CFG_INTERPOLATION, 24'd0);
                    write_reg(CFG_HALL_CHECK, 24'd0);
                end
                1:
                begin
                    write_reg(CFG_ROTOR_OFFSET, 24'hFFFFFF);
                    write_reg(CFG_INTERPOLATION, 24'd1);
                    write_reg(CFG_HALL_CHECK, 24'd1);
                end
                2:
                begin
                    write_reg(CFG_ROTOR_OFFSET, 24'($urandom));
                    write_reg(CFG_INTERPOLATION, 24'd1);
                    write_reg(CFG_HALL_CHECK, 24'd0);
                end
                3:
                begin
                    write_reg(CFG_ROTOR_OFFSET, ROTOR_OFFSET_RST);
                    write_reg(CFG_INTERPOLATION, 24'd0);
                    write_reg(CFG_HALL_CHECK, 24'd1);
                    write_reg(CFG_UNUSED, 24'($urandom));
                end
                4:
                begin
                    write_reg(CFG_ROTOR_OFFSET, 24'($urandom));
                    write_reg(CFG_INTERPOLATION, 24'($urandom_range(0, 1)));
                    write_reg(CFG_HALL_CHECK, 24'($urandom_range(0, 1)));
                end
                default:
                begin
                    write_reg(CFG_ROTOR_OFFSET, 24'($urandom));
                    write_reg(CFG_INTERPOLATION, 24'd1);
                    write_reg(CFG_HALL_CHECK, 24'd1);
                end
            endcase
            // the third stretch and the closing one run at full rate, with no idling at all
            idle_on = (ph != 2) && (ph != 5);
            while (sent < 25 + (ph + 1) * 146)
            begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 6)) send_noise();
                else
                    run_commutation($urandom_range(4, 30));
            end
        end

        drain();
        $display("Sent %0d requests over the reset defaults and six register settings.", sent);
        $display("Compared %0d results; %0d stall and %0d hall shutdowns seen.",
                 checked, stall_seen, hall_seen);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== rotor_sync_phase_tracker.f =====
rtl/rsp_pkg.sv
rtl/rotor_sync_phase_tracker.sv
tb/phase_tracker_checker.sv
tb/tb.sv
